### hw/rtl/brp_pkg.sv
// Shared constants, types and helper functions of the quarter-turn image rotator.
package brp_pkg;

	localparam int MAX_DIM    = 256;
	localparam int PIXEL_BITS = 24;
	localparam int PIX_BYTES  = PIXEL_BITS / 8;

	localparam int DIM_W   = $clog2(MAX_DIM);
	localparam int DIM_CW  = DIM_W + 1;
	localparam int ADDR_W  = 2 * DIM_W;
	localparam int CNT_W   = ADDR_W + 1;
	localparam int DEPTH   = MAX_DIM * MAX_DIM;
	localparam int CFG_W   = 9;

	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;
	localparam int REG_IW  = APB_AW - 2;

	localparam int QDEPTH  = 4;
	localparam int QAW     = $clog2(QDEPTH);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [REG_IW-1:0] REG_SRC_WIDTH  = REG_IW'(0);
	localparam logic [REG_IW-1:0] REG_SRC_HEIGHT = REG_IW'(1);

	typedef struct packed {
		logic [DIM_CW-1:0] w;
		logic [DIM_CW-1:0] h;
		logic [CNT_W-1:0]  total;
	} cfg_t;

	typedef struct packed {
		logic                  is_read;
		logic [ADDR_W-1:0]     addr;
		logic [PIXEL_BITS-1:0] pix;
		logic [1:0]            pad;
		logic                  row_end;
		logic                  image_end;
	} cmd_t;

	// A register value of zero acts as one, anything above the maximum as the maximum.
	function automatic logic [DIM_CW-1:0] eff_dim(input logic [CFG_W-1:0] v);
		logic [DIM_CW-1:0] r;
		if (v == '0) begin
			r = DIM_CW'(1);
		end else if (int'(v) > MAX_DIM) begin
			r = DIM_CW'(MAX_DIM);
		end else begin
			r = DIM_CW'(v);
		end
		return r;
	endfunction

	// Zero bytes that bring a row of n pixels up to a multiple of four bytes.
	function automatic logic [1:0] row_pad(input logic [DIM_CW-1:0] n);
		logic [DIM_CW+2:0] bytes;
		logic [DIM_CW+2:0] line;
		logic [DIM_CW+2:0] diff;
		bytes = (DIM_CW+3)'(n) * (DIM_CW+3)'(PIX_BYTES);
		line  = (bytes + (DIM_CW+3)'(3)) & ~(DIM_CW+3)'(3);
		diff  = line - bytes;
		return diff[1:0];
	endfunction

endpackage

### hw/rtl/brp_in_if.sv
// Input channel: one load or read-request word per handshake.
interface brp_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] pixel_blue;
	logic [7:0] pixel_green;
	logic [7:0] pixel_red;

	modport source (output valid, opcode, pixel_blue, pixel_green, pixel_red, input ready);
	modport sink (input valid, opcode, pixel_blue, pixel_green, pixel_red, output ready);
endinterface

### hw/rtl/brp_out_if.sv
// Output channel: one rotated pixel word per handshake.
interface brp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_blue;
	logic [7:0] out_green;
	logic [7:0] out_red;
	logic [1:0] pad_after;
	logic       row_end;
	logic       image_end;

	modport source (output valid, out_blue, out_green, out_red, pad_after, row_end, image_end,
		input ready);
	modport sink (input valid, out_blue, out_green, out_red, pad_after, row_end, image_end,
		output ready);
endinterface

### hw/rtl/brp_ram.sv
// Generic simple dual-port RAM with a registered, enabled read.
module brp_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### hw/rtl/brp_front.sv
// Front end: accepts words, tracks load and readout position, issues store commands.
module brp_front
	import brp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	brp_in_if.sink      item,
	input  cfg_t        cfg,
	input  logic        q_full,
	output logic        push,
	output cmd_t        push_cmd
);
	logic [CNT_W-1:0]  load_cnt_q;
	logic [DIM_W-1:0]  out_row_q;
	logic [DIM_W-1:0]  out_col_q;

	logic              take;
	logic              full;
	logic              outside;
	logic              rend;
	logic              iend;
	logic [CNT_W-1:0]  prod;
	logic [DIM_CW-1:0] col_off;
	logic [CNT_W-1:0]  rd_addr;

	assign item.ready = !q_full;
	assign take       = item.valid && !q_full;

	assign full    = load_cnt_q >= cfg.total;
	assign outside = ({1'b0, out_row_q} >= cfg.w) || ({1'b0, out_col_q} >= cfg.h);
	assign rend    = {1'b0, out_col_q} == (cfg.h - DIM_CW'(1));
	assign iend    = rend && ({1'b0, out_row_q} == (cfg.w - DIM_CW'(1)));

	// Source index of the rotated pixel: column times width plus mirrored row.
	assign prod    = CNT_W'(out_col_q) * CNT_W'(cfg.w);
	assign col_off = cfg.w - DIM_CW'(1) - {1'b0, out_row_q};
	assign rd_addr = prod + CNT_W'(col_off);

	always_comb begin
		push              = 1'b0;
		push_cmd.is_read  = item.opcode;
		push_cmd.pix      = {item.pixel_red, item.pixel_green, item.pixel_blue};
		push_cmd.pad      = rend ? row_pad(cfg.h) : 2'd0;
		push_cmd.row_end  = rend;
		push_cmd.image_end = iend;
		push_cmd.addr     = (item.opcode == OP_READ) ? rd_addr[ADDR_W-1:0]
			: load_cnt_q[ADDR_W-1:0];
		if (take) begin
			if (item.opcode == OP_LOAD) begin
				push = !full;
			end else begin
				push = full && !outside;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
		end else if (take) begin
			if (item.opcode == OP_LOAD) begin
				if (!full) begin
					load_cnt_q <= load_cnt_q + CNT_W'(1);
				end
			end else if (full) begin
				if (outside || iend) begin
					load_cnt_q <= '0;
					out_row_q  <= '0;
					out_col_q  <= '0;
				end else if (rend) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + DIM_W'(1);
				end else begin
					out_col_q <= out_col_q + DIM_W'(1);
				end
			end
		end
	end
endmodule

### hw/rtl/brp_queue.sv
// Short command queue between the front end and the store back end.
module brp_queue
	import brp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic full,
	output logic empty
);
	cmd_t           ent_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign full  = count_q == (QAW+1)'(QDEPTH);
	assign empty = count_q == '0;
	assign head  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QAW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QAW+1)'(1);
			end
		end
	end
endmodule

### hw/rtl/brp_back.sv
// Back end: executes store writes and reads, and holds the output register.
module brp_back
	import brp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  cmd_t        head,
	output logic        pop,
	brp_out_if.source   result
);
	logic                  s1_v_q;
	logic [1:0]            pad_s1;
	logic                  rend_s1;
	logic                  iend_s1;
	logic                  s1_go;
	logic                  re;
	logic                  we;
	logic [PIXEL_BITS-1:0] rdata;

	logic                  out_v_q;
	logic [PIXEL_BITS-1:0] pix_q;
	logic [1:0]            pad_q;
	logic                  rend_q;
	logic                  iend_q;

	// The read register reloads only when empty or its word moves on, so it holds under stall.
	assign s1_go = s1_v_q && (!out_v_q || result.ready);
	assign pop   = !q_empty && (!head.is_read || !s1_v_q || s1_go);
	assign re    = pop && head.is_read;
	assign we    = pop && !head.is_read;

	brp_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (head.addr),
		.wdata (head.pix),
		.re    (re),
		.raddr (head.addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (re) begin
			pad_s1  <= head.pad;
			rend_s1 <= head.row_end;
			iend_s1 <= head.image_end;
		end
		if (s1_go) begin
			pix_q  <= rdata;
			pad_q  <= pad_s1;
			rend_q <= rend_s1;
			iend_q <= iend_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			s1_v_q <= (s1_v_q && !s1_go) || re;
			if (s1_go) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign result.valid     = out_v_q;
	assign result.out_blue  = pix_q[7:0];
	assign result.out_green = pix_q[15:8];
	assign result.out_red   = pix_q[23:16];
	assign result.pad_after = pad_q;
	assign result.row_end   = rend_q;
	assign result.image_end = iend_q;
endmodule

### hw/rtl/bmp_rotate_90_with_row_padding.sv
// Top level of the quarter-turn image rotator with row padding.
//
//   Channel  Direction  Handshake              Contents
//   item     in         valid/ready            opcode, pixel_blue/green/red
//   result   out        valid/ready            out_blue/green/red, pad_after, row_end, image_end
//   config   in         APB (psel/penable)     src_width at 0x0, src_height at 0x4
//
// One word per cycle is sustained in both directions while the output is ready. The queue
// hands the back end one command per cycle, so the frame store takes one write or one read
// each cycle, and that sets the figure.
// A read word reaches the output through the command queue, the store's read register and
// the output register.
// Reset clears the counters, the queue and the output valid; the frame store is
// not cleared, as only loaded entries are ever read back.
// A stalled output holds its word while the queue keeps taking input words until full.
module bmp_rotate_90_with_row_padding
	import brp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	brp_in_if.sink            item,
	brp_out_if.source         result
);
	logic [CFG_W-1:0]  src_width_q;
	logic [CFG_W-1:0]  src_height_q;
	logic [REG_IW-1:0] reg_idx;
	logic              wr_en;
	cfg_t              cfg;

	logic              q_full;
	logic              q_empty;
	logic              push;
	logic              pop;
	cmd_t              push_cmd;
	cmd_t              head;

	// The register file: the low two address bits are ignored, so each word
	// address maps onto one register.
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_AW-1:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= CFG_W'(1);
			src_height_q <= CFG_W'(1);
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SRC_WIDTH: begin
					src_width_q <= pwdata[CFG_W-1:0];
				end
				REG_SRC_HEIGHT: begin
					src_height_q <= pwdata[CFG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_SRC_WIDTH: begin
				prdata = APB_DW'(src_width_q);
			end
			REG_SRC_HEIGHT: begin
				prdata = APB_DW'(src_height_q);
			end
			default: begin
			end
		endcase
	end

	// Effective sizes and the frame size follow the registers directly, so a word
	// accepted in the cycle after a register write already sees the new shape.
	assign cfg.w     = eff_dim(src_width_q);
	assign cfg.h     = eff_dim(src_height_q);
	assign cfg.total = CNT_W'(cfg.w) * CNT_W'(cfg.h);

	// Front end classifies each word: a load into a frame with room, a read of
	// a full frame, or a word that is dropped (possibly restarting the image).
	brp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg      (cfg),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// Commands are executed in order, so a read always follows the loads before it.
	brp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	brp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.head    (head),
		.pop     (pop),
		.result  (result)
	);
endmodule

### hw/rtl/brp_checker.sv
// Port-level checks of the rotator's output channel, bound to the top level.
module brp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_blue,
	input logic [7:0] out_green,
	input logic [7:0] out_red,
	input logic [1:0] pad_after,
	input logic       row_end,
	input logic       image_end
);
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_blue) && $stable(out_green)
			&& $stable(out_red) && $stable(pad_after) && $stable(row_end)
			&& $stable(image_end))
		else $error("stalled output word changed");

	a_image_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_end |-> row_end)
		else $error("image end without row end");

	a_pad_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (pad_after != 2'd0) |-> row_end)
		else $error("padding inside a row");
endmodule

bind bmp_rotate_90_with_row_padding brp_checker u_brp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_blue  (result.out_blue),
	.out_green (result.out_green),
	.out_red   (result.out_red),
	.pad_after (result.pad_after),
	.row_end   (result.row_end),
	.image_end (result.image_end)
);
